// ===== src/mbc_pkg.sv =====
// Shared types, constants and round function of the Magma-style block cipher.
package mbc_pkg;

  localparam int NumRounds = 32;
  localparam int NumKeys   = 8;
  localparam int HalfW     = 32;
  localparam int BlockW    = 2 * HalfW;
  localparam int RotAmt    = 11;
  localparam int KeyIdxW   = $clog2(NumKeys);
  localparam int CountW    = $clog2(NumRounds + 1);

  typedef enum logic {
    CmdEncrypt = 1'b0,
    CmdDecrypt = 1'b1
  } cmd_e;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [NumKeys-1:0][HalfW-1:0] key_words_t;

  // One request in flight: p is the half fed to the round function, q the other.
  typedef struct packed {
    cmd_e  cmd;
    half_t p;
    half_t q;
  } stage_t;

  localparam logic [3:0] SboxTab [0:7][0:15] = '{
    '{4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
      4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2},
    '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'hA, 4'h5, 4'hC,
      4'h1, 4'hE, 4'h4, 4'h7, 4'hB, 4'hD, 4'hF, 4'h0},
    '{4'hD, 4'h3, 4'h4, 4'hF, 4'h8, 4'h1, 4'hA, 4'h6,
      4'h9, 4'h0, 4'h7, 4'hC, 4'hB, 4'h5, 4'hE, 4'h2},
    '{4'hB, 4'h0, 4'h6, 4'h1, 4'h5, 4'hA, 4'h8, 4'hE,
      4'h3, 4'hD, 4'h7, 4'hC, 4'hF, 4'h9, 4'h2, 4'h4},
    '{4'h7, 4'h2, 4'hC, 4'h5, 4'h8, 4'h4, 4'h6, 4'hB,
      4'h1, 4'hA, 4'h9, 4'hE, 4'h3, 4'hF, 4'h0, 4'hD},
    '{4'h5, 4'hB, 4'h0, 4'hC, 4'h7, 4'hA, 4'h4, 4'h8,
      4'hE, 4'h2, 4'hD, 4'h6, 4'hF, 4'h1, 4'h3, 4'h9},
    '{4'hA, 4'hD, 4'h0, 4'h3, 4'h6, 4'h9, 4'h2, 4'h8,
      4'hB, 4'h1, 4'h7, 4'h5, 4'hF, 4'h4, 4'hE, 4'hC},
    '{4'hC, 4'h8, 4'h2, 4'h1, 4'hD, 4'h4, 4'hF, 4'h6,
      4'h7, 4'h0, 4'hA, 4'h5, 4'h3, 4'hE, 4'h9, 4'hB}
  };

  // Key add, nibble substitution, then rotate left.
  function automatic half_t round_f(input half_t x, input half_t k);
    half_t s;
    half_t t;
    s = x + k;
    for (int n = 0; n < HalfW / 4; n++) begin
      t[4*n +: 4] = SboxTab[n][s[4*n +: 4]];
    end
    return {t[HalfW-1-RotAmt:0], t[HalfW-1:HalfW-RotAmt]};
  endfunction

endpackage

// ===== src/mbc_key_regs.sv =====
// Round key register file, written through the configuration port.
module mbc_key_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mbc_pkg::KeyIdxW-1:0]  cfg_idx_i,
  input  mbc_pkg::half_t               cfg_wdata_i,
  output mbc_pkg::key_words_t          keys_o
);

  mbc_pkg::key_words_t keys_q, keys_d;

  always_comb begin
    keys_d = keys_q;
    if (cfg_we_i) begin
      keys_d[cfg_idx_i] = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
    end else begin
      keys_q <= keys_d;
    end
  end

  assign keys_o = keys_q;

endmodule

// ===== src/mbc_round.sv =====
// One Feistel round with its pipeline register and per-stage flow control.
module mbc_round (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mbc_pkg::half_t   key_enc_i,
  input  mbc_pkg::half_t   key_dec_i,
  input  logic             valid_i,
  input  mbc_pkg::stage_t  data_i,
  output logic             ready_o,
  output logic             valid_o,
  output mbc_pkg::stage_t  data_o,
  input  logic             ready_i
);

  logic            valid_q, valid_d;
  mbc_pkg::stage_t data_q, data_d;
  mbc_pkg::half_t  key;

  // The stage takes a new request when it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;
  assign key     = (data_i.cmd == mbc_pkg::CmdDecrypt) ? key_dec_i : key_enc_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
    if (ready_o && valid_i) begin
      data_d.cmd = data_i.cmd;
      data_d.p   = data_i.q ^ mbc_pkg::round_f(data_i.p, key);
      data_d.q   = data_i.p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/magma_block_cipher.sv =====
// Top level of the pipelined 64-bit Magma-style block cipher.
//
// Usage: the eight 32-bit round key words are written through the plain
// configuration port (cfg_we_i, cfg_idx_i selects key word 0 to 7,
// cfg_wdata_i holds the word). Keys must only change while no request is in
// flight. Blocks enter on the slave stream: tdata carries the eight block
// bytes as a little-endian 64-bit word, tuser selects encryption (0) or
// decryption (1). Results leave on the master stream as a 64-bit tdata.
//
// Each of the 32 rounds has its own register stage, so when the receiver
// does not stall one request can be accepted in every cycle and a result
// leaves from the last round register. Throughput without stalls is one block
// per cycle, set by the single round of logic between stage registers.
//
// Reset clears all stage valid bits and sets every key word to zero. When
// the receiver stalls, the last stage holds its result; earlier stages keep
// moving until they catch up with a full stage, so bubbles are squeezed out
// and the slave side stays ready until all 32 stages hold a request.
module magma_block_cipher (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [mbc_pkg::KeyIdxW-1:0]  cfg_idx_i,
  input  logic [mbc_pkg::HalfW-1:0]    cfg_wdata_i,
  // Request stream.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [mbc_pkg::BlockW-1:0]   s_axis_tdata_i,   // [63:0] block_in
  input  logic                         s_axis_tuser_i,   // [0] command
  // Result stream.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [mbc_pkg::BlockW-1:0]   m_axis_tdata_o    // [63:0] block_out
);

  localparam int N = mbc_pkg::NumRounds;

  mbc_pkg::key_words_t keys;
  logic                stg_valid [0:N];
  logic                stg_ready [0:N];
  mbc_pkg::stage_t     stg_data  [0:N];

  mbc_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .keys_o      (keys)
  );

  // Both directions feed the high half of the input word to the first round;
  // only the key order differs, running backwards for decryption.
  assign stg_valid[0]     = s_axis_tvalid_i;
  assign stg_data[0].cmd  = mbc_pkg::cmd_e'(s_axis_tuser_i);
  assign stg_data[0].p    = s_axis_tdata_i[mbc_pkg::BlockW-1:mbc_pkg::HalfW];
  assign stg_data[0].q    = s_axis_tdata_i[mbc_pkg::HalfW-1:0];
  assign s_axis_tready_o  = stg_ready[0];

  for (genvar r = 0; r < N; r++) begin : g_round
    localparam int KeyEnc = r % mbc_pkg::NumKeys;
    localparam int KeyDec = mbc_pkg::NumKeys - 1 - KeyEnc;

    mbc_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_enc_i (keys[KeyEnc]),
      .key_dec_i (keys[KeyDec]),
      .valid_i   (stg_valid[r]),
      .data_i    (stg_data[r]),
      .ready_o   (stg_ready[r]),
      .valid_o   (stg_valid[r+1]),
      .data_o    (stg_data[r+1]),
      .ready_i   (stg_ready[r+1])
    );
  end

  // The last round register doubles as the output register.
  assign stg_ready[N]    = m_axis_tready_i;
  assign m_axis_tvalid_o = stg_valid[N];
  assign m_axis_tdata_o  = {stg_data[N].q, stg_data[N].p};

endmodule

// ===== src/mbc_checker.sv =====
// Port-level checks for the block cipher, bound to the top level.
module mbc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_o,
  input  logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  input  logic [mbc_pkg::BlockW-1:0]   m_axis_tdata_o
);

  logic [mbc_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                       in_acc;
  logic                       out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // Requests accepted but not yet delivered.
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input not ready although output stage is empty");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> cnt_q != '0)
    else $error("result shown without an outstanding request");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mbc_pkg::CountW'(mbc_pkg::NumRounds))
    else $error("more requests in flight than pipeline stages");

endmodule

bind magma_block_cipher mbc_checker u_mbc_checker (.*);
